/* rtl/core/kvl_pkg.sv */
package kvl_pkg;

    localparam int MaxKeys   = 64;
    localparam int FracBits  = 16;
    localparam int SlotW     = 6;
    localparam int CountW    = 7;
    localparam int DataW     = 32;
    localparam int CfgIdxW   = 1;

    localparam logic [CfgIdxW-1:0] CfgKeyCount = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgEmptyDef = 1'd1;

    localparam logic OpWrite = 1'b0;
    localparam logic OpQuery = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [SlotW-1:0]    key_slot;
        logic [DataW-1:0]    time_value;
        logic signed [DataW-1:0] key_x;
        logic signed [DataW-1:0] key_y;
        logic signed [DataW-1:0] key_z;
    } t_in_word;

    typedef struct packed {
        logic signed [DataW-1:0] out_x;
        logic signed [DataW-1:0] out_y;
        logic signed [DataW-1:0] out_z;
        logic [SlotW-1:0]        segment;
        logic                    clamped;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_LOAD_SEG,
        S_SEG_WAIT,
        S_DIV,
        S_BLEND_RD,
        S_BLEND_MUL,
        S_BLEND_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             latch_in;
        logic             do_write;
        logic             srch_cmp;
        logic             load_seg;
        logic             div_start;
        logic             div_step;
        logic             blend_rd;
        logic             blend_mul;
        logic             blend_add;
        logic             out_load;
        logic [1:0]       comp;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic search_done;
        logic div_done;
        logic trivial;
    } t_status;

endpackage

/* rtl/core/kvl_if.sv */
interface kvl_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/kvl_ctrl.sv */
module kvl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  kvl_pkg::t_status i_status,
    output kvl_pkg::t_cmd    o_cmd
);
    kvl_pkg::t_state r_state, n_state;
    logic [1:0] r_comp, n_comp;
    logic       r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvl_pkg::S_IDLE;
            r_comp <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp <= n_comp;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_comp = r_comp;
        case (r_state)
            kvl_pkg::S_IDLE:
                if (i_in_valid) n_state = kvl_pkg::S_WRITE;
            kvl_pkg::S_WRITE: begin
                n_comp = 2'd0;
                if (!i_status.is_query) n_state = kvl_pkg::S_IDLE;
                else if (i_status.trivial) n_state = kvl_pkg::S_OUT;
                else n_state = kvl_pkg::S_SRCH_RD;
            end
            kvl_pkg::S_SRCH_RD: n_state = kvl_pkg::S_SRCH_CMP;
            kvl_pkg::S_SRCH_CMP:
                n_state = i_status.search_done ? kvl_pkg::S_LOAD_SEG : kvl_pkg::S_SRCH_RD;
            kvl_pkg::S_LOAD_SEG: n_state = kvl_pkg::S_SEG_WAIT;
            kvl_pkg::S_SEG_WAIT: n_state = kvl_pkg::S_DIV;
            kvl_pkg::S_DIV:
                if (i_status.div_done) n_state = kvl_pkg::S_BLEND_RD;
            kvl_pkg::S_BLEND_RD: n_state = kvl_pkg::S_BLEND_MUL;
            kvl_pkg::S_BLEND_MUL: n_state = kvl_pkg::S_BLEND_ADD;
            kvl_pkg::S_BLEND_ADD: begin
                n_comp = r_comp + 2'd1;
                n_state = (r_comp == 2'd2) ? kvl_pkg::S_OUT : kvl_pkg::S_BLEND_RD;
            end
            kvl_pkg::S_OUT:
                if (!r_out_valid || i_out_ready) n_state = kvl_pkg::S_IDLE;
            default: n_state = kvl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.comp = r_comp;
        o_in_ready = 1'b0;
        case (r_state)
            kvl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            kvl_pkg::S_WRITE: begin
                o_cmd.do_write = !i_status.is_query;
            end
            kvl_pkg::S_SRCH_RD: ;
            kvl_pkg::S_SRCH_CMP: o_cmd.srch_cmp = 1'b1;
            kvl_pkg::S_LOAD_SEG: o_cmd.load_seg = 1'b1;
            kvl_pkg::S_SEG_WAIT: o_cmd.div_start = 1'b1;
            kvl_pkg::S_DIV: o_cmd.div_step = 1'b1;
            kvl_pkg::S_BLEND_RD: o_cmd.blend_rd = 1'b1;
            kvl_pkg::S_BLEND_MUL: o_cmd.blend_mul = 1'b1;
            kvl_pkg::S_BLEND_ADD: o_cmd.blend_add = 1'b1;
            kvl_pkg::S_OUT: o_cmd.out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == kvl_pkg::S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comp != 2'd3 || r_state == kvl_pkg::S_OUT || r_state == kvl_pkg::S_IDLE
        || r_state == kvl_pkg::S_WRITE)
        else $error("component counter overrun");
endmodule

/* rtl/core/kvl_dp.sv */
module kvl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kvl_pkg::t_cmd                 i_cmd,
    output kvl_pkg::t_status              o_status,
    input  kvl_pkg::t_in_word             i_in,
    input  logic                          i_cfg_we,
    input  logic [kvl_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [kvl_pkg::DataW-1:0]     i_cfg_data,
    output kvl_pkg::t_out_word            o_out
);
    localparam int W = kvl_pkg::DataW;
    localparam int F = kvl_pkg::FracBits;
    localparam int SW = kvl_pkg::SlotW;

    logic [W-1:0] mem_t [kvl_pkg::MaxKeys];
    logic [3*W-1:0] mem_v [kvl_pkg::MaxKeys];

    logic [kvl_pkg::CountW-1:0] r_count;
    logic [W-1:0] r_default;
    kvl_pkg::t_in_word r_in;
    logic [SW-1:0] r_rd_addr;
    logic [W-1:0] r_rd_t;
    logic [3*W-1:0] r_rd_v;
    logic [SW-1:0] r_idx, r_seg;
    logic r_found;
    logic [W-1:0] r_t1, r_t2;
    logic [3*W-1:0] r_v1, r_v2;
    logic [1:0] r_seg_phase;
    logic [F:0] r_f;
    logic r_clamped;
    logic [W+F-1:0] r_rem;
    logic [W-1:0] r_den;
    logic [5:0] r_bits;
    logic r_div_done;
    logic signed [W:0] r_diff;
    logic signed [W+F+1:0] r_prod;
    logic signed [W-1:0] r_p1;
    logic signed [W-1:0] r_res [3];
    kvl_pkg::t_out_word r_out;

    logic [kvl_pkg::CountW-1:0] n_keys;
    assign n_keys = (r_count > kvl_pkg::CountW'(kvl_pkg::MaxKeys))
        ? kvl_pkg::CountW'(kvl_pkg::MaxKeys) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_default <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == kvl_pkg::CfgKeyCount) r_count <= i_cfg_data[kvl_pkg::CountW-1:0];
            else if (i_cfg_idx == kvl_pkg::CfgEmptyDef) r_default <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            mem_t[r_in.key_slot] <= r_in.time_value;
            mem_v[r_in.key_slot] <= {r_in.key_z, r_in.key_y, r_in.key_x};
        end
        r_rd_t <= mem_t[r_rd_addr];
        r_rd_v <= mem_v[r_rd_addr];
    end

    logic [W-1:0] q;
    logic [W:0] num_s, den_s;
    logic [W+F:0] trial;
    logic [F:0] f_w;
    assign q = r_in.time_value;
    assign num_s = {1'b0, q} - {1'b0, r_t1};
    assign den_s = {1'b0, r_t2} - {1'b0, r_t1};
    assign trial = {r_rem, 1'b0} - {{(F+1){1'b0}}, r_den};
    assign f_w = r_f;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in;
            r_idx <= '0;
            r_found <= 1'b0;
            // single-key query reads slot 0 during the write state
            r_rd_addr <= (n_keys < kvl_pkg::CountW'(2)) ? SW'(0) : SW'(1);
        end
        if (i_cmd.srch_cmp) begin
            if (!r_found && q < r_rd_t) begin
                r_found <= 1'b1;
                r_seg <= r_idx;
            end
            r_idx <= r_idx + SW'(1);
            r_rd_addr <= r_idx + SW'(2);
        end
        if (i_cmd.load_seg) begin
            if (!r_found) r_seg <= SW'(n_keys - kvl_pkg::CountW'(2));
            r_rd_addr <= r_found ? r_seg : SW'(n_keys - kvl_pkg::CountW'(2));
            r_seg_phase <= 2'd0;
        end
        if (i_cmd.div_start) begin
            r_rd_addr <= r_seg + SW'(1);
            r_seg_phase <= 2'd2;
            r_div_done <= 1'b0;
        end
        if (i_cmd.div_step) begin
            if (r_seg_phase == 2'd2) begin
                r_t1 <= r_rd_t;
                r_v1 <= r_rd_v;
                r_seg_phase <= 2'd1;
            end else if (r_seg_phase == 2'd1) begin
                r_t2 <= r_rd_t;
                r_v2 <= r_rd_v;
                r_seg_phase <= 2'd0;
                r_bits <= '0;
            end else if (r_bits == 6'd0 && !r_div_done) begin
                if (den_s[W] || den_s == '0) begin
                    r_f <= '0; r_clamped <= 1'b0; r_div_done <= 1'b1;
                end else if (num_s[W]) begin
                    r_f <= '0; r_clamped <= 1'b1; r_div_done <= 1'b1;
                end else if (num_s >= den_s) begin
                    r_f <= (F+1)'(1) << F;
                    r_clamped <= (num_s != den_s);
                    r_div_done <= 1'b1;
                end else begin
                    r_rem <= (W+F)'(num_s[W-1:0]);
                    r_den <= den_s[W-1:0];
                    r_f <= '0;
                    r_clamped <= 1'b0;
                    r_bits <= 6'd1;
                end
            end else if (!r_div_done) begin
                if (!trial[W+F]) begin
                    r_rem <= trial[W+F-1:0];
                    r_f <= {r_f[F-1:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[W+F-2:0], 1'b0};
                    r_f <= {r_f[F-1:0], 1'b0};
                end
                if (r_bits == 6'(F)) r_div_done <= 1'b1;
                r_bits <= r_bits + 6'd1;
            end
        end
        if (i_cmd.blend_rd) begin
            r_p1 <= r_v1[i_cmd.comp*W +: W];
            r_diff <= (W+1)'($signed(r_v2[i_cmd.comp*W +: W]))
                    - (W+1)'($signed(r_v1[i_cmd.comp*W +: W]));
        end
        if (i_cmd.blend_mul)
            r_prod <= (W+F+2)'(r_diff) * $signed({1'b0, f_w});
        if (i_cmd.blend_add)
            r_res[i_cmd.comp] <= r_p1 + W'(r_prod >>> F);
        if (i_cmd.out_load) begin
            if (n_keys == '0) begin
                r_out <= {r_default, r_default, r_default, SW'(0), 1'b0};
            end else if (n_keys == kvl_pkg::CountW'(1)) begin
                r_out <= {r_rd_v[W-1:0], r_rd_v[2*W-1:W], r_rd_v[3*W-1:2*W], SW'(0), 1'b0};
            end else begin
                r_out <= {r_res[0], r_res[1], r_res[2], r_seg, r_clamped};
            end
        end
    end

    assign o_status.is_query = (r_in.operation == kvl_pkg::OpQuery);
    assign o_status.trivial = (n_keys < kvl_pkg::CountW'(2));
    assign o_status.search_done = r_found || (q < r_rd_t)
        || ({1'b0, r_idx} + kvl_pkg::CountW'(2) >= n_keys);
    assign o_status.div_done = r_div_done && (r_seg_phase == 2'd0);
    assign o_out = r_out;
endmodule

/* rtl/core/keyframe_vector_lerp.sv */
// channel | dir | payload
// in_ch   | in  | operation, key_slot, time_value, key_x/y/z
// out_ch  | out | out_x/y/z, segment, clamped
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// A write passes the idle and write states; a query with zero or one key goes idle, write, output.
// A larger query searches the key table, then runs a 16-step divide unless the factor
// clamps or the key times do not rise, then blends each component; a new word waits for idle.
// Reset clears control, key count and empty default; key table is undefined until written.
// Output register holds a result until taken; the next query waits in its output state.
module keyframe_vector_lerp (
    input  logic i_clk,
    input  logic i_rst_n,
    kvl_if.sink   in_ch,
    kvl_if.source out_ch,
    input  logic                        i_cfg_we,
    input  logic [kvl_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [kvl_pkg::DataW-1:0]   i_cfg_data
);
    kvl_pkg::t_cmd    cmd;
    kvl_pkg::t_status status;

    kvl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    kvl_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status), .i_in(in_ch.data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_out(out_ch.data)
    );
endmodule
